### design/lmfs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lmfs_pkg
// Types, codes and helpers shared by the LIN master frame sender.
// ----------------------------------------------------------------------------
package lmfs_pkg;

  // input operations
  localparam logic [1:0] OP_HEADER = 2'd0;
  localparam logic [1:0] OP_DATA   = 2'd1;
  localparam logic [1:0] OP_ABORT  = 2'd2;

  // frame phase
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_MASTER = 2'd1;
  localparam logic [1:0] PH_SLAVE  = 2'd2;

  // byte kinds on the result channel
  localparam logic [2:0] KIND_BREAK = 3'd0;
  localparam logic [2:0] KIND_SYNC  = 3'd1;
  localparam logic [2:0] KIND_PID   = 3'd2;
  localparam logic [2:0] KIND_DATA  = 3'd3;
  localparam logic [2:0] KIND_CSUM  = 3'd4;
  localparam logic [2:0] KIND_NONE  = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BUSY    = 2'd1;
  localparam logic [1:0] ST_UNEXP   = 2'd2;
  localparam logic [1:0] ST_ABORTED = 2'd3;

  // queued command kinds
  localparam logic [1:0] CMD_HDR  = 2'd0;
  localparam logic [1:0] CMD_DATA = 2'd1;
  localparam logic [1:0] CMD_EVT  = 2'd2;

  localparam logic [7:0] BREAK_BYTE = 8'h00;
  localparam logic [7:0] SYNC_BYTE  = 8'h55;

  typedef struct packed {
    logic [1:0] operation;
    logic [5:0] frame_id;
    logic       enhanced_checksum;
    logic       slave_response;
    logic [3:0] data_length;
    logic [7:0] data_byte;
  } lmfs_in_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic [2:0] byte_kind;
    logic [1:0] status;
    logic       frame_done;
    logic       last;
  } lmfs_out_t;

  // one classified item, expanded into beats by the back end
  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] byte_val;   // PID for a header, data byte for data
    logic [7:0] csum;       // inverted checksum, valid when has_csum
    logic       has_csum;
    logic       slave;
    logic [1:0] status;
  } lmfs_cmd_t;

  function automatic logic [7:0] make_pid(input logic [5:0] id);
    logic p0;
    logic p1;
    p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
    p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
    return {p1, p0, id};
  endfunction

  // 8-bit add with end-around carry
  function automatic logic [7:0] fold_add(input logic [7:0] acc, input logic [7:0] v);
    logic [8:0] s;
    s = {1'b0, acc} + {1'b0, v};
    return s[7:0] + {7'd0, s[8]};
  endfunction

endpackage
`default_nettype wire

### design/lmfs_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lmfs_front
// Accepts input items, tracks the frame phase and checksum, and pushes one
// classified command per header, data or abort item into the queue.
// ----------------------------------------------------------------------------
module lmfs_front #(
  parameter int MAX_DATA_BYTES = 8
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  lmfs_pkg::lmfs_in_t    in_data,
  input  wire                   q_full,
  output logic                  q_push,
  output lmfs_pkg::lmfs_cmd_t   q_cmd
);
  import lmfs_pkg::*;

  localparam logic [3:0] MAX_LEN = 4'(MAX_DATA_BYTES);

  logic [1:0] phase_r, phase_nxt;
  logic [3:0] expected_r, expected_nxt;
  logic [3:0] sent_r, sent_nxt;
  logic [7:0] sum_r, sum_nxt;

  logic       accept;
  logic [3:0] len_sat;
  logic [7:0] pid;
  logic [7:0] sum_start;
  logic [7:0] sum_new;
  logic [3:0] sent_new;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  assign len_sat   = (in_data.data_length > MAX_LEN) ? MAX_LEN : in_data.data_length;
  assign pid       = make_pid(in_data.frame_id);
  assign sum_start = in_data.enhanced_checksum ? pid : 8'h00;
  assign sum_new   = fold_add(sum_r, in_data.data_byte);
  assign sent_new  = sent_r + 4'd1;

  always_comb begin
    phase_nxt    = phase_r;
    expected_nxt = expected_r;
    sent_nxt     = sent_r;
    sum_nxt      = sum_r;
    q_push       = 1'b0;
    q_cmd        = '0;
    q_cmd.cmd    = CMD_EVT;
    if (accept) begin
      unique case (in_data.operation)
        OP_HEADER: begin
          q_push = 1'b1;
          if (phase_r != PH_IDLE) begin
            q_cmd.status = ST_BUSY;
          end else begin
            q_cmd.cmd      = CMD_HDR;
            q_cmd.byte_val = pid;
            q_cmd.csum     = ~sum_start;
            q_cmd.slave    = in_data.slave_response;
            q_cmd.has_csum = !in_data.slave_response && (len_sat == 4'd0);
            sent_nxt       = 4'd0;
            if (in_data.slave_response) begin
              phase_nxt    = PH_SLAVE;
              expected_nxt = len_sat;
              sum_nxt      = sum_start;
            end else if (len_sat == 4'd0) begin
              phase_nxt    = PH_IDLE;
              expected_nxt = 4'd0;
              sum_nxt      = 8'h00;
            end else begin
              phase_nxt    = PH_MASTER;
              expected_nxt = len_sat;
              sum_nxt      = sum_start;
            end
          end
        end
        OP_DATA: begin
          q_push = 1'b1;
          if (phase_r != PH_MASTER) begin
            q_cmd.status = ST_UNEXP;
          end else begin
            q_cmd.cmd      = CMD_DATA;
            q_cmd.byte_val = in_data.data_byte;
            q_cmd.csum     = ~sum_new;
            q_cmd.has_csum = (sent_new >= expected_r);
            if (sent_new >= expected_r) begin
              phase_nxt    = PH_IDLE;
              expected_nxt = 4'd0;
              sent_nxt     = 4'd0;
              sum_nxt      = 8'h00;
            end else begin
              sent_nxt = sent_new;
              sum_nxt  = sum_new;
            end
          end
        end
        OP_ABORT: begin
          q_push       = 1'b1;
          q_cmd.status = ST_ABORTED;
          phase_nxt    = PH_IDLE;
          expected_nxt = 4'd0;
          sent_nxt     = 4'd0;
          sum_nxt      = 8'h00;
        end
        default: begin
          // unused operation: swallowed, no result
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      expected_r <= 4'd0;
      sent_r     <= 4'd0;
      sum_r      <= 8'h00;
    end else begin
      phase_r    <= phase_nxt;
      expected_r <= expected_nxt;
      sent_r     <= sent_nxt;
      sum_r      <= sum_nxt;
    end
  end

endmodule
`default_nettype wire

### design/lmfs_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lmfs_queue
// Four-entry command queue between front and back end.
// ----------------------------------------------------------------------------
module lmfs_queue (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   push,
  input  lmfs_pkg::lmfs_cmd_t   push_cmd,
  input  wire                   pop,
  output logic                  full,
  output logic                  empty,
  output lmfs_pkg::lmfs_cmd_t   head
);
  import lmfs_pkg::*;

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  lmfs_cmd_t       mem [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [AW:0]     count_r, count_nxt;

  assign full  = (count_r == (AW+1)'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

### design/lmfs_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lmfs_back
// Steps through the head command one beat per cycle, while the output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module lmfs_back (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   q_empty,
  input  lmfs_pkg::lmfs_cmd_t   q_head,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire                   out_stall,
  output lmfs_pkg::lmfs_out_t   out_data
);
  import lmfs_pkg::*;

  logic [1:0] step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;
  lmfs_out_t  out_data_r, out_data_nxt;
  lmfs_out_t  beat;
  logic       load;
  logic       fire;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // beat for the current step of the head command
  always_comb begin
    beat = '0;
    beat.status    = ST_OK;
    unique case (q_head.cmd)
      CMD_HDR: begin
        unique case (step_r)
          2'd0: begin
            beat.tx_byte   = BREAK_BYTE;
            beat.byte_kind = KIND_BREAK;
          end
          2'd1: begin
            beat.tx_byte   = SYNC_BYTE;
            beat.byte_kind = KIND_SYNC;
          end
          2'd2: begin
            beat.tx_byte    = q_head.byte_val;
            beat.byte_kind  = KIND_PID;
            beat.frame_done = q_head.slave;
            beat.last       = !q_head.has_csum;
          end
          2'd3: begin
            beat.tx_byte    = q_head.csum;
            beat.byte_kind  = KIND_CSUM;
            beat.frame_done = 1'b1;
            beat.last       = 1'b1;
          end
        endcase
      end
      CMD_DATA: begin
        if (step_r == 2'd0) begin
          beat.tx_byte   = q_head.byte_val;
          beat.byte_kind = KIND_DATA;
          beat.last      = !q_head.has_csum;
        end else begin
          beat.tx_byte    = q_head.csum;
          beat.byte_kind  = KIND_CSUM;
          beat.frame_done = 1'b1;
          beat.last       = 1'b1;
        end
      end
      default: begin
        beat.byte_kind = KIND_NONE;
        beat.status    = q_head.status;
        beat.last      = 1'b1;
      end
    endcase
  end

  assign load = !out_valid_r || !out_stall;
  assign fire = load && !q_empty;

  always_comb begin
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    if (fire) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = beat;
      if (beat.last) begin
        step_nxt = 2'd0;
        q_pop    = 1'b1;
      end else begin
        step_nxt = step_r + 2'd1;
      end
    end else if (load) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

### design/lin_master_frame_sender.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lin_master_frame_sender
// LIN master frame sender: header, data and abort items in, line bytes out.
//
// Input channel (in_valid/in_stall/in_data): header, data byte or abort items.
// Items are classified on acceptance (PID and parity, checksum, phase) and
// queued in a four-entry command queue. in_stall rises only when it is full.
// Result channel (out_valid/out_stall/out_data): one beat per line byte or
// status event, from an output register. A header gives break, sync and PID
// (plus the checksum for a zero-length master frame); a data item gives the
// byte and, for the last one, the checksum; rejects and aborts give one beat.
// With an empty queue an accepted item is first written into the queue, and
// its first beat is then loaded into the output register. The back end sends
// one beat per cycle while out_stall is low, so an item gives one to four beats.
// Items are taken every cycle while the queue has room.
// Reset: synchronous, active low; the block returns to idle, queue empty.
// A stalled receiver holds the output beat; the queue then fills and stalls
// the input.
// ----------------------------------------------------------------------------
module lin_master_frame_sender #(
  parameter int MAX_DATA_BYTES = 8
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  lmfs_pkg::lmfs_in_t   in_data,
  output logic                 out_valid,
  input  wire                  out_stall,
  output lmfs_pkg::lmfs_out_t  out_data
);
  import lmfs_pkg::*;

  logic      q_full;
  logic      q_empty;
  logic      q_push;
  logic      q_pop;
  lmfs_cmd_t q_cmd;
  lmfs_cmd_t q_head;

  lmfs_front #(
    .MAX_DATA_BYTES(MAX_DATA_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  lmfs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (q_head)
  );

  lmfs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

### design/lmfs_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lmfs_checker
// Port-level checks on the result channel of the LIN master frame sender.
// ----------------------------------------------------------------------------
module lmfs_checker (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  out_valid,
  input wire                  out_stall,
  input lmfs_pkg::lmfs_out_t  out_data
);
  import lmfs_pkg::*;

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // error and abort beats carry no byte and end their item
  a_status_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |->
      out_data.byte_kind == KIND_NONE && out_data.tx_byte == 8'h00 && out_data.last)
    else $error("status beat malformed");

  a_done_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_done |->
      (out_data.byte_kind == KIND_CSUM || out_data.byte_kind == KIND_PID)
      && out_data.last)
    else $error("frame_done on a wrong beat");

  a_break_sync: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.byte_kind == KIND_BREAK || out_data.byte_kind == KIND_SYNC) |->
      !out_data.last && out_data.status == ST_OK
      && (out_data.byte_kind == KIND_BREAK ? out_data.tx_byte == BREAK_BYTE
                                           : out_data.tx_byte == SYNC_BYTE))
    else $error("break or sync beat malformed");

endmodule

bind lin_master_frame_sender lmfs_checker u_lmfs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
